### rtl/core/lbf_pkg.sv
// Shared types and constants for the LED breath and flash pattern generator.
// No dependencies; imported by every module of the block.
package lbf_pkg;

   localparam int PEAK_W     = 8;
   localparam int PERIOD_W   = 10;
   localparam int LENGTH_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int ELAPSED_W  = 16;
   localparam int PHASE_W    = 11;   // breath phase, holds periods up to 2047
   localparam int WEIGHT_W   = 17;   // Q0.16 weight, 0..65536
   localparam int COLOR_W    = 8;

   localparam logic [CSR_IDX_W-1:0] REG_PEAK_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_ON     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_LENGTH = 2'd3;

   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_SET_MODE = 1'b1;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_BREATHE = 2'd1,
      MODE_APPROVE = 2'd2,
      MODE_DENY    = 2'd3
   } mode_type;

   // Per-tick info handed from the control stage to the output stage.
   typedef struct packed {
      logic                 tick;
      logic                 breathe;
      logic [PEAK_W-1:0]    peak;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
   } tick_info_type;

endpackage

### rtl/core/led_breath_and_flash_pattern.sv
// LED breath and flash pattern generator: top level with the output pipeline.
// Depends on lbf_pkg, lbf_ctrl and lbf_weight_rom.

// Each request is either a one-millisecond tick (tuser 0) or a set-mode
// request (tuser 1, mode in tdata[1:0]: off, red breathing, green approve
// flash, red deny flash). Every tick yields one color, computed from the
// counters as they stood before that tick; set-mode requests yield nothing.
// One request is taken per clock while the result side keeps up; a tick's
// color passes the registered weight table read and then the registered
// peak-times-weight multiply. A stalled result holds the whole pipeline and
// lowers req_tready. The weight table holds BREATH_PERIOD_MS/2+1 entries,
// built at elaboration.
module led_breath_and_flash_pattern
   import lbf_pkg::*;
#(
   parameter int BREATH_PERIOD_MS = 1200
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [1:0] mode_request
   input  logic                  req_tuser,   // [0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int HALF   = BREATH_PERIOD_MS / 2 + 1;
   localparam int ADDR_W = (HALF > 1) ? $clog2(HALF) : 1;

   logic                  advance;
   logic                  accept;
   tick_info_type         info;
   logic [PHASE_W-1:0]    breath_q;
   logic [WEIGHT_W-1:0]   weight;

   logic                  s1_valid_ff;
   tick_info_type         s1_info_ff;
   logic                  s2_valid_ff;
   logic [COLOR_W-1:0]    red_ff, red_in;
   logic [COLOR_W-1:0]    green_ff;
   logic [PEAK_W+WEIGHT_W-1:0] product;

   assign advance    = !s2_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   lbf_ctrl #(
      .BREATH_PERIOD_MS (BREATH_PERIOD_MS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_tuser),
      .mode_request (req_tdata[1:0]),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .info         (info),
      .breath_q     (breath_q)
   );

   lbf_weight_rom #(
      .BREATH_PERIOD_MS (BREATH_PERIOD_MS),
      .ADDR_W           (ADDR_W)
   ) u_rom (
      .clock   (clock),
      .rd_en   (advance),
      .rd_addr (breath_q[ADDR_W-1:0]),
      .rd_data (weight)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && info.tick;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_info_ff <= info;
         red_ff     <= red_in;
         green_ff   <= s1_info_ff.green;
      end
   end

   always_comb begin
      product = (PEAK_W+WEIGHT_W)'(s1_info_ff.peak) * (PEAK_W+WEIGHT_W)'(weight);
      red_in  = s1_info_ff.breathe ? product[16 +: COLOR_W] : s1_info_ff.red;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {8'h00, green_ff, red_ff};

   // ---- assertions ----
   a_blue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:16] == 8'h00))
      else $error("blue channel not zero");

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'h00 || rsp_tdata[15:8] == 8'h00))
      else $error("red and green lit together");

   a_set_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == KIND_SET_MODE) |=> !s1_valid_ff)
      else $error("set-mode request produced a result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

endmodule

### rtl/core/lbf_weight_rom.sv
// Raised-cosine weight table for the breathing pattern, built at elaboration.
// Registered read. Depends on lbf_pkg.
module lbf_weight_rom
   import lbf_pkg::*;
#(
   parameter int BREATH_PERIOD_MS = 1200,
   parameter int ADDR_W           = 10
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [WEIGHT_W-1:0] rd_data
);

   localparam int HALF = BREATH_PERIOD_MS / 2 + 1;
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   typedef logic [WEIGHT_W-1:0] weight_tab_type [HALF];

   // sin^2 in Q0.16 by a floored Taylor series to the x^15 term
   function automatic logic [WEIGHT_W-1:0] calc_weight(int q);
      longint unsigned x, x2, term, sum, w;
      x    = (PI_Q30 * longint'(unsigned'(q))) / BREATH_PERIOD_MS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         case (k)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            5: term = term / 110;
            6: term = term / 156;
            default: term = term / 210;
         endcase
         if (k % 2 == 1) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > ONE_Q30) sum = ONE_Q30;
      w = (sum * sum + (64'd1 << 43)) >> 44;
      if (w > 64'd65536) w = 64'd65536;
      return WEIGHT_W'(w);
   endfunction

   function automatic weight_tab_type build_tab();
      weight_tab_type tab;
      for (int i = 0; i < HALF; i++) begin
         tab[i] = calc_weight(i);
      end
      return tab;
   endfunction

   localparam weight_tab_type WEIGHT_TAB = build_tab();

   logic [WEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= WEIGHT_TAB[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lbf_ctrl.sv
// Mode and counter state, configuration registers and per-tick flash decision.
// Depends on lbf_pkg.
module lbf_ctrl
   import lbf_pkg::*;
#(
   parameter int BREATH_PERIOD_MS = 1200
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  kind,
   input  logic [1:0]            mode_request,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output tick_info_type         info,
   output logic [PHASE_W-1:0]    breath_q
);

   localparam logic [PHASE_W-1:0] BP = PHASE_W'(BREATH_PERIOD_MS);

   logic [PEAK_W-1:0]    peak_ff;
   logic [PERIOD_W-1:0]  period_ff;
   logic [PERIOD_W-1:0]  on_ff;
   logic [LENGTH_W-1:0]  length_ff;
   mode_type             mode_ff, mode_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [PHASE_W-1:0]   breath_ff, breath_in;
   logic [PERIOD_W-1:0]  flash_ff, flash_in;

   logic [PERIOD_W-1:0]  eff_period;
   logic [PERIOD_W:0]    flash_inc;
   logic [PHASE_W-1:0]   breath_inc;
   logic [PHASE_W-1:0]   breath_rem;
   logic                 flashing;
   logic                 flash_done;
   logic                 lit;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= PEAK_W'(200);
         period_ff <= PERIOD_W'(300);
         on_ff     <= PERIOD_W'(150);
         length_ff <= LENGTH_W'(900);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PEAK_LEVEL:   peak_ff   <= csr_wr_data[PEAK_W-1:0];
            REG_FLASH_PERIOD: period_ff <= csr_wr_data[PERIOD_W-1:0];
            REG_FLASH_ON:     on_ff     <= csr_wr_data[PERIOD_W-1:0];
            REG_FLASH_LENGTH: length_ff <= csr_wr_data[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         elapsed_ff <= '0;
         breath_ff  <= '0;
         flash_ff   <= '0;
      end else begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         breath_ff  <= breath_in;
         flash_ff   <= flash_in;
      end
   end

   always_comb begin
      eff_period = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
      flash_inc  = {1'b0, flash_ff} + (PERIOD_W+1)'(1);
      breath_inc = breath_ff + PHASE_W'(1);
      flashing   = (mode_ff == MODE_APPROVE) || (mode_ff == MODE_DENY);
      flash_done = (elapsed_ff >= length_ff);
      lit        = flashing && !flash_done && (flash_ff < on_ff);

      // fold the phase onto the rising half of the table
      breath_rem = BP - breath_ff;
      breath_q   = (breath_rem < breath_ff) ? breath_rem : breath_ff;

      info.tick    = (kind == KIND_TICK);
      info.breathe = (mode_ff == MODE_BREATHE);
      info.peak    = peak_ff;
      info.red     = (lit && mode_ff == MODE_DENY) ? peak_ff : '0;
      info.green   = (lit && mode_ff == MODE_APPROVE) ? peak_ff : '0;

      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      breath_in  = breath_ff;
      flash_in   = flash_ff;

      if (accept) begin
         if (kind == KIND_TICK) begin
            if (flashing && flash_done) begin
               mode_in = MODE_OFF;
            end
            if (elapsed_ff != '1) elapsed_in = elapsed_ff + ELAPSED_W'(1);
            breath_in = (breath_inc >= BP) ? '0 : breath_inc;
            flash_in  = (flash_inc >= {1'b0, eff_period}) ? '0 : flash_inc[PERIOD_W-1:0];
         end else if (!flashing && mode_type'(mode_request) != mode_ff) begin
            mode_in    = mode_type'(mode_request);
            elapsed_in = '0;
            breath_in  = '0;
            flash_in   = '0;
         end
      end
   end

endmodule
